// File: sv/mi3_pkg.sv
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    // cofactor: difference of two 64-bit products
    localparam int COF_W         = 65;
    // determinant: sum of three 32 x 65 bit products
    localparam int DET_W         = 97;
    localparam int N_ELEM        = 9;
    localparam int QUEUE_DEPTH   = 2;
    // 18 cofactor products, then 6 partial products for the determinant
    localparam int N_COF_STEPS   = 18;
    localparam int N_STEPS       = 24;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_11;
        logic signed [ELEM_W-1:0] elem_12;
        logic signed [ELEM_W-1:0] elem_13;
        logic signed [ELEM_W-1:0] elem_21;
        logic signed [ELEM_W-1:0] elem_22;
        logic signed [ELEM_W-1:0] elem_23;
        logic signed [ELEM_W-1:0] elem_31;
        logic signed [ELEM_W-1:0] elem_32;
        logic signed [ELEM_W-1:0] elem_33;
    } mi3_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_11;
        logic signed [ELEM_W-1:0] inv_12;
        logic signed [ELEM_W-1:0] inv_13;
        logic signed [ELEM_W-1:0] inv_21;
        logic signed [ELEM_W-1:0] inv_22;
        logic signed [ELEM_W-1:0] inv_23;
        logic signed [ELEM_W-1:0] inv_31;
        logic signed [ELEM_W-1:0] inv_32;
        logic signed [ELEM_W-1:0] inv_33;
        logic                     singular;
        logic                     saturated;
    } mi3_out_t;

    typedef struct packed {
        logic [N_ELEM-1:0][COF_W-1:0] cof;
        logic [DET_W-1:0]             det;
        logic                         singular;
    } mi3_job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_DRAIN,
        FR_PUSH
    } mi3_front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_CHECK,
        BK_DIV,
        BK_WRITE,
        BK_OUT
    } mi3_back_state_t;

    // Cofactor k of the adjugate is a[x]*a[y] - a[u]*a[v]; returns {x, y, u, v}.
    function automatic logic [15:0] cof_terms(input logic [3:0] k);
        logic [15:0] t;
        begin
            case (k)
                4'd0:    t = {4'd4, 4'd8, 4'd5, 4'd7};
                4'd1:    t = {4'd7, 4'd2, 4'd1, 4'd8};
                4'd2:    t = {4'd1, 4'd5, 4'd4, 4'd2};
                4'd3:    t = {4'd5, 4'd6, 4'd3, 4'd8};
                4'd4:    t = {4'd0, 4'd8, 4'd2, 4'd6};
                4'd5:    t = {4'd3, 4'd2, 4'd0, 4'd5};
                4'd6:    t = {4'd3, 4'd7, 4'd6, 4'd4};
                4'd7:    t = {4'd6, 4'd1, 4'd0, 4'd7};
                4'd8:    t = {4'd0, 4'd4, 4'd1, 4'd3};
                default: t = 16'd0;
            endcase
            return t;
        end
    endfunction

endpackage

// File: sv/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// Request channel: drive matrix and raise start; the request is taken at a
// rising edge where start is high and busy is low. Hold start only as long
// as needed; busy stays high while the front end forms the cofactors.
// Result channel: done pulses for one cycle with result valid in that cycle.
// The receiver cannot stall, so take the result on the done cycle or drop it.
// Front end: one shared 33x33 multiplier forms nine exact cofactors and the
// exact determinant; busy drops again as soon as the job is in the
// two-entry queue.
// Back end: a restoring divider, one quotient bit a cycle, takes the nine
// elements in turn; this divider sets throughput.
// When the determinant is zero the division is skipped: all elements are
// zero and singular is set.
// Reset clears the queue and both sequencers; no result is pending after it.
module matrix_inverse_3x3
#(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mi3_pkg::mi3_in_t   matrix,
    output logic               done,
    output mi3_pkg::mi3_out_t  result
);

    // front end to queue
    logic              push;
    logic              q_full;
    mi3_pkg::mi3_job_t push_job;

    // queue to back end
    logic              pop;
    logic              q_empty;
    mi3_pkg::mi3_job_t pop_job;

    mi3_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .matrix (matrix),
        .push   (push),
        .job    (push_job),
        .q_full (q_full)
    );

    // decouple the multiplier sequence from the divider
    mi3_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (q_empty)
    );

    mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (pop_job),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

// File: sv/mi3_front.sv
module mi3_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mi3_pkg::mi3_in_t   matrix,
    output logic               push,
    output mi3_pkg::mi3_job_t  job,
    input  logic               q_full
);

    mi3_pkg::mi3_front_state_t state_reg;
    mi3_pkg::mi3_front_state_t state_next;

    logic signed [mi3_pkg::ELEM_W-1:0] a_reg   [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::COF_W-1:0]  cof_reg [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::DET_W-1:0]  det_reg;
    logic signed [65:0]                prod_reg;
    logic [4:0]                        step_reg;
    logic [4:0]                        pstep_reg;
    logic                              pvld_reg;

    logic                              accept;
    logic [15:0]                       terms;
    logic [4:0]                        dj;
    logic [4:0]                        pdj;
    logic [1:0]                        jdx;
    logic [3:0]                        ci;
    logic signed [32:0]                mul_a;
    logic signed [32:0]                mul_b;

    assign accept = start && (state_reg == mi3_pkg::FR_IDLE);

    // operand selection for the shared multiplier
    always_comb
    begin
        terms = mi3_pkg::cof_terms(step_reg[4:1]);
        dj    = step_reg - 5'(mi3_pkg::N_COF_STEPS);
        jdx   = dj[2:1];
        ci    = {1'b0, jdx, 1'b0} + {2'b0, jdx};
        mul_a = '0;
        mul_b = '0;
        if (step_reg < 5'(mi3_pkg::N_COF_STEPS))
        begin
            if (!step_reg[0])
            begin
                mul_a = {a_reg[terms[15:12]][31], a_reg[terms[15:12]]};
                mul_b = {a_reg[terms[11:8]][31], a_reg[terms[11:8]]};
            end
            else
            begin
                mul_a = {a_reg[terms[7:4]][31], a_reg[terms[7:4]]};
                mul_b = {a_reg[terms[3:0]][31], a_reg[terms[3:0]]};
            end
        end
        else
        begin
            mul_a = {a_reg[jdx][31], a_reg[jdx]};
            if (!dj[0])
                mul_b = {1'b0, cof_reg[ci][31:0]};
            else
                mul_b = cof_reg[ci][64:32];
        end
    end

    assign pdj = pstep_reg - 5'(mi3_pkg::N_COF_STEPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mi3_pkg::FR_IDLE;
            pvld_reg  <= 1'b0;
            step_reg  <= '0;
            pstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pvld_reg  <= (state_reg == mi3_pkg::FR_MUL);
            pstep_reg <= step_reg;
            if (accept)
                step_reg <= '0;
            else if (state_reg == mi3_pkg::FR_MUL)
                step_reg <= step_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg[0] <= matrix.elem_11;
            a_reg[1] <= matrix.elem_12;
            a_reg[2] <= matrix.elem_13;
            a_reg[3] <= matrix.elem_21;
            a_reg[4] <= matrix.elem_22;
            a_reg[5] <= matrix.elem_23;
            a_reg[6] <= matrix.elem_31;
            a_reg[7] <= matrix.elem_32;
            a_reg[8] <= matrix.elem_33;
            det_reg  <= '0;
        end
        else if (pvld_reg)
        begin
            if (pstep_reg < 5'(mi3_pkg::N_COF_STEPS))
            begin
                if (!pstep_reg[0])
                    cof_reg[pstep_reg[4:1]] <= prod_reg[64:0];
                else
                    cof_reg[pstep_reg[4:1]] <= cof_reg[pstep_reg[4:1]] - prod_reg[64:0];
            end
            else if (!pdj[0])
                det_reg <= det_reg + {{31{prod_reg[65]}}, prod_reg};
            else
                det_reg <= det_reg + {prod_reg[64:0], 32'b0};
        end
        if (state_reg == mi3_pkg::FR_MUL)
            prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mi3_pkg::FR_IDLE:  if (start) state_next = mi3_pkg::FR_MUL;
            mi3_pkg::FR_MUL:
                if (step_reg == 5'(mi3_pkg::N_STEPS - 1)) state_next = mi3_pkg::FR_DRAIN;
            mi3_pkg::FR_DRAIN: state_next = mi3_pkg::FR_PUSH;
            mi3_pkg::FR_PUSH:  if (!q_full) state_next = mi3_pkg::FR_IDLE;
            default:           state_next = mi3_pkg::FR_IDLE;
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        push = 1'b0;
        case (state_reg)
            mi3_pkg::FR_IDLE: busy = 1'b0;
            mi3_pkg::FR_PUSH: push = !q_full;
            default:          busy = 1'b1;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
            job.cof[i] = cof_reg[i];
        job.det      = det_reg;
        job.singular = (det_reg == '0);
    end

endmodule

// File: sv/mi3_queue.sv
module mi3_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mi3_pkg::mi3_job_t  push_data,
    output logic               full,
    input  logic               pop,
    output mi3_pkg::mi3_job_t  pop_data,
    output logic               empty
);

    localparam int PTR_W = $clog2(mi3_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mi3_pkg::QUEUE_DEPTH + 1);

    mi3_pkg::mi3_job_t mem_reg [mi3_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(mi3_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(mi3_pkg::QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + PTR_W'(1);
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(mi3_pkg::QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_W'(push && !full) - CNT_W'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: sv/mi3_back.sv
module mi3_back
#(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  mi3_pkg::mi3_job_t  q_data,
    output logic               pop,
    output logic               done,
    output mi3_pkg::mi3_out_t  result
);

    localparam int NUM_W  = 64 + 2 * FRAC_BITS;
    localparam int WIDE_W = (NUM_W > 129) ? NUM_W : 129;

    mi3_pkg::mi3_back_state_t state_reg;
    mi3_pkg::mi3_back_state_t state_next;

    logic [mi3_pkg::COF_W-1:0]  cof_reg [mi3_pkg::N_ELEM];
    logic [31:0]                inv_reg [mi3_pkg::N_ELEM];
    logic [mi3_pkg::DET_W-1:0]  dmag_reg;
    logic                       dneg_reg;
    logic                       sing_reg;
    logic                       sat_reg;
    logic                       cneg_reg;
    logic                       big_reg;
    logic [3:0]                 idx_reg;
    logic [4:0]                 step_reg;
    logic [WIDE_W-1:0]          rem_reg;
    logic [WIDE_W-1:0]          dsh_reg;
    logic [31:0]                q_reg;
    logic                       done_reg;
    mi3_pkg::mi3_out_t          result_reg;

    logic [mi3_pkg::COF_W-1:0]  cur_cof;
    logic [mi3_pkg::COF_W-1:0]  cof_mag;
    logic                       ge;
    logic                       neg;
    logic [31:0]                res;
    logic                       res_sat;
    mi3_pkg::mi3_out_t          result_next;

    assign cur_cof = cof_reg[idx_reg];
    assign cof_mag = cur_cof[mi3_pkg::COF_W-1] ? (~cur_cof + 1'b1) : cur_cof;
    assign ge      = (rem_reg >= dsh_reg);
    assign neg     = cneg_reg ^ dneg_reg;

    // clip the 32-bit quotient magnitude into signed range
    always_comb
    begin
        res     = q_reg;
        res_sat = 1'b0;
        if (neg)
        begin
            if (big_reg || (q_reg > 32'h8000_0000))
            begin
                res     = 32'h8000_0000;
                res_sat = 1'b1;
            end
            else
                res = ~q_reg + 32'd1;
        end
        else if (big_reg || q_reg[31])
        begin
            res     = 32'h7FFF_FFFF;
            res_sat = 1'b1;
        end
    end

    always_comb
    begin
        result_next.inv_11    = sing_reg ? '0 : inv_reg[0];
        result_next.inv_12    = sing_reg ? '0 : inv_reg[1];
        result_next.inv_13    = sing_reg ? '0 : inv_reg[2];
        result_next.inv_21    = sing_reg ? '0 : inv_reg[3];
        result_next.inv_22    = sing_reg ? '0 : inv_reg[4];
        result_next.inv_23    = sing_reg ? '0 : inv_reg[5];
        result_next.inv_31    = sing_reg ? '0 : inv_reg[6];
        result_next.inv_32    = sing_reg ? '0 : inv_reg[7];
        result_next.inv_33    = sing_reg ? '0 : inv_reg[8];
        result_next.singular  = sing_reg;
        result_next.saturated = sat_reg && !sing_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mi3_pkg::BK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == mi3_pkg::BK_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mi3_pkg::BK_IDLE:
                if (!q_empty)
                begin
                    for (int i = 0; i < mi3_pkg::N_ELEM; i++)
                        cof_reg[i] <= q_data.cof[i];
                    dneg_reg <= q_data.det[mi3_pkg::DET_W-1];
                    dmag_reg <= q_data.det[mi3_pkg::DET_W-1] ? (~q_data.det + 1'b1)
                                                             : q_data.det;
                    sing_reg <= q_data.singular;
                    sat_reg  <= 1'b0;
                    idx_reg  <= '0;
                end
            mi3_pkg::BK_LOAD:
            begin
                cneg_reg <= cur_cof[mi3_pkg::COF_W-1];
                rem_reg  <= WIDE_W'(cof_mag) << (2 * FRAC_BITS);
                dsh_reg  <= WIDE_W'(dmag_reg) << 31;
            end
            mi3_pkg::BK_CHECK:
            begin
                big_reg  <= (rem_reg >= {dsh_reg[WIDE_W-2:0], 1'b0});
                step_reg <= 5'd31;
                q_reg    <= '0;
            end
            mi3_pkg::BK_DIV:
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh_reg;
                q_reg    <= {q_reg[30:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - 5'd1;
            end
            mi3_pkg::BK_WRITE:
            begin
                inv_reg[idx_reg] <= res;
                sat_reg          <= sat_reg | res_sat;
                idx_reg          <= idx_reg + 4'd1;
            end
            mi3_pkg::BK_OUT:
                result_reg <= result_next;
            default:
                sat_reg <= sat_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mi3_pkg::BK_IDLE:
                if (!q_empty)
                    state_next = q_data.singular ? mi3_pkg::BK_OUT : mi3_pkg::BK_LOAD;
            mi3_pkg::BK_LOAD:  state_next = mi3_pkg::BK_CHECK;
            mi3_pkg::BK_CHECK:
                state_next = (rem_reg >= {dsh_reg[WIDE_W-2:0], 1'b0}) ? mi3_pkg::BK_WRITE
                                                                     : mi3_pkg::BK_DIV;
            mi3_pkg::BK_DIV:
                if (step_reg == 5'd0) state_next = mi3_pkg::BK_WRITE;
            mi3_pkg::BK_WRITE:
                state_next = (idx_reg == 4'(mi3_pkg::N_ELEM - 1)) ? mi3_pkg::BK_OUT
                                                                  : mi3_pkg::BK_LOAD;
            mi3_pkg::BK_OUT:   state_next = mi3_pkg::BK_IDLE;
            default:           state_next = mi3_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            mi3_pkg::BK_IDLE: pop = !q_empty;
            default:          pop = 1'b0;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.singular) |->
            (!result.saturated && result.inv_11 == '0 && result.inv_22 == '0
             && result.inv_33 == '0))
        else $error("singular result with nonzero elements or saturation");

    a_write_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mi3_pkg::BK_WRITE) |->
            ($past(state_reg) == mi3_pkg::BK_DIV || $past(state_reg) == mi3_pkg::BK_CHECK))
        else $error("element written without a division");

endmodule
